// ----- rtl/bfa_pkg.sv -----
// Shared constants, codes and types for the bitmap first-free allocator.
package bfa_pkg;

   // Default sizing of the bitmap
   localparam int ENTRIES_DEF   = 8192;
   localparam int WORD_BITS_DEF = 32;

   // Fixed field widths of the request, response and CSR
   localparam int FIELD_W  = 14;
   localparam int STATUS_W = 2;

   // Entry limit after reset
   localparam logic [FIELD_W-1:0] LIMIT_RESET = FIELD_W'(8192);

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_FULL         = 2'd1,
      ST_RANGE        = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   // Flags from the word unit to the sequencer
   typedef struct packed {
      logic hit;       // a usable clear bit exists in the word
      logic bit_set;   // selected bit is currently set
   } word_stat_type;

endpackage

// ----- rtl/bfa_if.sv -----
// Request and response channel interfaces of the bitmap allocator.
interface bfa_req_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [FIELD_W-1:0] entry_number;

   modport source (output valid, output action, output entry_number, input ready);
   modport sink   (input valid, input action, input entry_number, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  entry_number_out;
   logic [STATUS_W-1:0] status;
   logic [FIELD_W-1:0]  free_count;

   modport source (output valid, output entry_number_out, output status,
                   output free_count, input ready);
   modport sink   (input valid, input entry_number_out, input status,
                   input free_count, output ready);
endinterface

// ----- rtl/bfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- rtl/bfa_word_unit.sv -----
// Shared word unit: first usable clear bit, bit test, set and clear of one bitmap word.
module bfa_word_unit import bfa_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int LIM_W     = $clog2(ENTRIES_DEF + 1)
) (
   input  logic [WORD_BITS-1:0]         word_data,
   input  logic [LIM_W-1:0]             avail,      // entries left from word base to limit
   input  logic [$clog2(WORD_BITS)-1:0] bit_sel,
   output word_stat_type                stat,
   output logic [$clog2(WORD_BITS)-1:0] ffz_idx,
   output logic [WORD_BITS-1:0]         set_word,
   output logic [WORD_BITS-1:0]         clr_word
);

   localparam int BIT_W = $clog2(WORD_BITS);

   logic             hit;
   logic [BIT_W-1:0] idx;

   // Priority search for the lowest clear bit below the limit
   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (!word_data[j] && (32'(avail) > 32'(j))) begin
            hit = 1'b1;
            idx = BIT_W'(j);
         end
      end
   end

   assign ffz_idx      = idx;
   assign stat.hit     = hit;
   assign stat.bit_set = word_data[bit_sel];
   assign set_word     = word_data | (WORD_BITS'(1) << idx);
   assign clr_word     = word_data & ~(WORD_BITS'(1) << bit_sel);

endmodule

// ----- rtl/bitmap_first_free_allocator.sv -----
// Bitmap first-free allocator: sequencer, counters and bitmap RAM.
// Allocate: reads words from accept until the one holding a clear bit has been tested
// (one word per cycle, lowest first), or until the limit is reached when none is found.
// Free: word read, test and write back, response; a bad number goes straight to the response.
// One request at a time; the RAM's single read port paces the word scan.
// Reset: synchronous; a clearing pass then writes NUM_WORDS zero words (256 words by
// default) before the first request is accepted. Limit resets to 8192, used count to 0.
module bitmap_first_free_allocator import bfa_pkg::*; #(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF   // power of two
) (
   input  logic               clock,
   input  logic               reset,
   bfa_req_if.sink            req_chan,
   bfa_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data
);

   localparam int NUM_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WCNT_W    = $clog2(NUM_WORDS + 1);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int LIM_W     = $clog2(ENTRIES + 1);
   localparam int BASE_W    = WCNT_W + BIT_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_FRD, S_FCHK, S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [WADDR_W-1:0]  clr_ff, clr_in;
   logic [WCNT_W-1:0]   iss_ff, iss_in;
   logic [WADDR_W-1:0]  chk_ff, chk_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [LIM_W-1:0]    used_ff, used_in;
   logic [FIELD_W-1:0]  limit_ff, limit_in;
   logic [WADDR_W-1:0]  fr_word_ff, fr_word_in;
   logic [BIT_W-1:0]    fr_bit_ff, fr_bit_in;
   logic [FIELD_W-1:0]  fr_num_ff, fr_num_in;
   logic [LIM_W-1:0]    res_num_ff, res_num_in;
   status_type          res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_num_ff, rsp_num_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]  rsp_free_ff, rsp_free_in;

   logic [LIM_W-1:0]     eff_lim;
   logic [LIM_W-1:0]     free_left;
   logic [BASE_W-1:0]    iss_base;
   logic                 issue_ok;
   logic [LIM_W-1:0]     chk_base;
   logic [LIM_W-1:0]     avail;
   logic [FIELD_W-1:0]   req_pos;

   logic                 ram_we;
   logic [WADDR_W-1:0]   ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WADDR_W-1:0]   ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   word_stat_type        wstat;
   logic [BIT_W-1:0]     ffz_idx;
   logic [WORD_BITS-1:0] set_word;
   logic [WORD_BITS-1:0] clr_word;

   // Effective limit and free count
   assign eff_lim   = (32'(limit_ff) > 32'(ENTRIES)) ? LIM_W'(ENTRIES) : LIM_W'(limit_ff);
   assign free_left = (eff_lim > used_ff) ? (eff_lim - used_ff) : '0;

   // Scan addressing: next word to read and word whose data is back
   assign iss_base = {iss_ff, BIT_W'(0)};
   assign issue_ok = (state_ff == S_SCAN) && (iss_base < BASE_W'(eff_lim));
   assign chk_base = LIM_W'({chk_ff, BIT_W'(0)});
   assign avail    = eff_lim - chk_base;
   assign req_pos  = req_chan.entry_number - FIELD_W'(1);

   // Bitmap storage
   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Shared word unit
   bfa_word_unit #(
      .WORD_BITS (WORD_BITS),
      .LIM_W     (LIM_W)
   ) u_word (
      .word_data (ram_rdata),
      .avail     (avail),
      .bit_sel   (fr_bit_ff),
      .stat      (wstat),
      .ffz_idx   (ffz_idx),
      .set_word  (set_word),
      .clr_word  (clr_word)
   );

   // Channel ports
   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.entry_number_out = rsp_num_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.free_count       = rsp_free_ff;

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      iss_in        = iss_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      used_in       = used_ff;
      limit_in      = limit_ff;
      fr_word_in    = fr_word_ff;
      fr_bit_in     = fr_bit_ff;
      fr_num_in     = fr_num_ff;
      res_num_in    = res_num_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      ram_we        = 1'b0;
      ram_waddr     = chk_ff;
      ram_wdata     = set_word;
      ram_raddr     = WADDR_W'(iss_ff);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      case (state_ff)
         // Zero the bitmap one word a cycle
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == WADDR_W'(NUM_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + WADDR_W'(1);
            end
         end
         // Take a request
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.action == ACT_ALLOC) begin
                  iss_in     = '0;
                  chk_vld_in = 1'b0;
                  state_in   = S_SCAN;
               end else if ((req_chan.entry_number == '0) ||
                            (32'(req_chan.entry_number) > 32'(eff_lim))) begin
                  res_num_in = '0;
                  res_st_in  = ST_RANGE;
                  state_in   = S_DONE;
               end else begin
                  fr_word_in = WADDR_W'(req_pos >> BIT_W);
                  fr_bit_in  = BIT_W'(req_pos);
                  fr_num_in  = req_chan.entry_number;
                  state_in   = S_FRD;
               end
            end
         end
         // Read words in order, test each one as its data returns
         S_SCAN: begin
            iss_in     = issue_ok ? (iss_ff + WCNT_W'(1)) : iss_ff;
            chk_in     = WADDR_W'(iss_ff);
            chk_vld_in = issue_ok;
            if (chk_vld_ff && wstat.hit) begin
               ram_we     = 1'b1;
               ram_waddr  = chk_ff;
               ram_wdata  = set_word;
               if (used_ff < LIM_W'(ENTRIES)) begin
                  used_in = used_ff + LIM_W'(1);
               end
               res_num_in = chk_base + LIM_W'(ffz_idx) + LIM_W'(1);
               res_st_in  = ST_OK;
               chk_vld_in = 1'b0;
               state_in   = S_DONE;
            end else if (!chk_vld_ff && !issue_ok) begin
               res_num_in = '0;
               res_st_in  = ST_FULL;
               state_in   = S_DONE;
            end
         end
         // Read the word holding the entry to free
         S_FRD: begin
            ram_raddr = fr_word_ff;
            state_in  = S_FCHK;
         end
         // Test the bit, clear it if set
         S_FCHK: begin
            if (!wstat.bit_set) begin
               res_num_in = '0;
               res_st_in  = ST_ALREADY_FREE;
            end else begin
               ram_we     = 1'b1;
               ram_waddr  = fr_word_ff;
               ram_wdata  = clr_word;
               if (used_ff != '0) begin
                  used_in = used_ff - LIM_W'(1);
               end
               res_num_in = LIM_W'(fr_num_ff);
               res_st_in  = ST_OK;
            end
            state_in = S_DONE;
         end
         // Load the response register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = FIELD_W'(res_num_ff);
               rsp_status_in = res_st_ff;
               rsp_free_in   = FIELD_W'(free_left);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         used_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iss_ff        <= iss_in;
      chk_ff        <= chk_in;
      fr_word_ff    <= fr_word_in;
      fr_bit_ff     <= fr_bit_in;
      fr_num_ff     <= fr_num_in;
      res_num_ff    <= res_num_in;
      res_st_ff     <= res_st_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // No response can appear while the bitmap is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response valid during clearing pass");

   // Used count stays within the map
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= LIM_W'(ENTRIES))
      else $error("used count above entry count");

   // Failed requests report entry number zero
   a_err_num_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_num_ff == '0))
      else $error("error response with nonzero entry number");

   // Successful requests report a nonzero entry number
   a_ok_num_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_OK)) |-> (rsp_num_ff != '0))
      else $error("ok response with entry number zero");

   // An accepted request starts work on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && (state_ff == S_IDLE)) |=> (state_ff != S_IDLE))
      else $error("accepted request left the sequencer idle");

endmodule
